// File: design/usan_pkg.sv
// Shared types, byte constants and byte classifier for the UTF-8 sanitizer.
`default_nettype none

package usan_pkg;

   // Byte range limits
   localparam logic [7:0] ByteZero    = 8'h00;
   localparam logic [7:0] ByteAsciiHi = 8'h80;
   localparam logic [7:0] ByteContHi  = 8'hBF;
   localparam logic [7:0] ByteLead2Lo = 8'hC2;
   localparam logic [7:0] ByteLead2Hi = 8'hDF;
   localparam logic [7:0] ByteLead3Lo = 8'hE0;
   localparam logic [7:0] ByteLead3Hi = 8'hEF;
   localparam logic [7:0] ByteLead4Lo = 8'hF0;
   localparam logic [7:0] ByteLead4Hi = 8'hF4;

   // Sequence lengths opened by each lead
   localparam logic [2:0] SeqLenNone = 3'd0;
   localparam logic [2:0] SeqLen2    = 3'd2;
   localparam logic [2:0] SeqLen3    = 3'd3;
   localparam logic [2:0] SeqLen4    = 3'd4;

   // Default depth of the run queue between front and back
   localparam int QueueDepthDefault = 4;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_CONT,
      CLS_INVALID
   } byte_class_type;

   // One run of results: up to four bytes, emitted bytes[0] .. bytes[last_idx]
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            eos;
   } run_type;

   // Front to queue write side
   typedef struct packed {
      logic    push;
      run_type run;
   } queue_wr_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type cls;
      priority if (b == ByteZero)                        cls = CLS_ZERO;
      else if (b < ByteAsciiHi)                          cls = CLS_ASCII;
      else if (b <= ByteContHi)                          cls = CLS_CONT;
      else if (b >= ByteLead2Lo && b <= ByteLead2Hi)     cls = CLS_LEAD2;
      else if (b >= ByteLead3Lo && b <= ByteLead3Hi)     cls = CLS_LEAD3;
      else if (b >= ByteLead4Lo && b <= ByteLead4Hi)     cls = CLS_LEAD4;
      else                                               cls = CLS_INVALID;
      return cls;
   endfunction

endpackage

`default_nettype wire

// File: design/utf8_sanitizer_core.sv
// Path: the first word of a run reaches rsp through the queue write, then the output register,
// after the byte that completes it is taken; further words follow one per cycle unless stalled.
// Throughput: one byte per cycle in while the queue is not full, one result word per cycle out
// while rsp_stall is low; a finished run of up to four words drains from a QueueDepth-entry
// run queue, so a stalled output stalls input only once the queue is full.
// Reset: synchronous; clears pending sequence, queue pointers and output valid.
`default_nettype none

module utf8_sanitizer_core #(
   parameter int QueueDepth = usan_pkg::QueueDepthDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_end_of_string,
   output logic            rsp_last_of_run
);

   usan_pkg::queue_wr_type queue_wr;
   usan_pkg::run_type      head;
   logic                   queue_full;
   logic                   head_valid;
   logic                   pop;

   usan_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .queue_wr      (queue_wr)
   );

   usan_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   usan_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: design/usan_front.sv
// Front end: accepts raw bytes, tracks the pending sequence, queues complete runs.
`default_nettype none

module usan_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  queue_full,
   output usan_pkg::queue_wr_type     queue_wr
);

   logic [2:0]      seq_len_ff, seq_len_in;
   logic [1:0]      held_cnt_ff, held_cnt_in;
   logic [2:0][7:0] held_ff, held_in;
   logic            accept;
   usan_pkg::byte_class_type cls;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign cls       = usan_pkg::classify(req_data_byte);

   // Sequence tracking and run building
   always_comb begin
      seq_len_in  = seq_len_ff;
      held_cnt_in = held_cnt_ff;
      held_in     = held_ff;
      queue_wr    = '0;
      if (accept) begin
         if (seq_len_ff != usan_pkg::SeqLenNone && cls == usan_pkg::CLS_CONT) begin
            if ({1'b0, held_cnt_ff} + 3'd1 == seq_len_ff) begin
               // sequence complete: held bytes then this one
               queue_wr.push = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  queue_wr.run.bytes[i] = (held_cnt_ff == 2'(i)) ? req_data_byte
                                                                  : held_ff[i];
               end
               queue_wr.run.bytes[3]  = req_data_byte;
               queue_wr.run.last_idx  = held_cnt_ff;
               seq_len_in  = usan_pkg::SeqLenNone;
               held_cnt_in = 2'd0;
            end else begin
               held_in[held_cnt_ff] = req_data_byte;
               held_cnt_in          = held_cnt_ff + 2'd1;
            end
         end else begin
            // no sequence, or an early non-continuation drops what is held
            seq_len_in  = usan_pkg::SeqLenNone;
            held_cnt_in = 2'd0;
            unique case (cls)
               usan_pkg::CLS_ZERO: begin
                  queue_wr.push    = 1'b1;
                  queue_wr.run.eos = 1'b1;
               end
               usan_pkg::CLS_ASCII: begin
                  queue_wr.push         = 1'b1;
                  queue_wr.run.bytes[0] = req_data_byte;
               end
               usan_pkg::CLS_LEAD2: begin
                  seq_len_in  = usan_pkg::SeqLen2;
                  held_cnt_in = 2'd1;
                  held_in[0]  = req_data_byte;
               end
               usan_pkg::CLS_LEAD3: begin
                  seq_len_in  = usan_pkg::SeqLen3;
                  held_cnt_in = 2'd1;
                  held_in[0]  = req_data_byte;
               end
               usan_pkg::CLS_LEAD4: begin
                  seq_len_in  = usan_pkg::SeqLen4;
                  held_cnt_in = 2'd1;
                  held_in[0]  = req_data_byte;
               end
               usan_pkg::CLS_CONT, usan_pkg::CLS_INVALID: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff  <= usan_pkg::SeqLenNone;
         held_cnt_ff <= 2'd0;
      end else begin
         seq_len_ff  <= seq_len_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   // Held bytes, no reset
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

// File: design/usan_queue.sv
// Small FIFO of complete runs between front and back.
`default_nettype none

module usan_queue #(
   parameter int Depth = usan_pkg::QueueDepthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire usan_pkg::queue_wr_type queue_wr,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output usan_pkg::run_type          head
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   usan_pkg::run_type mem_ff [Depth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = queue_wr.push & ~full;
   assign do_pop     = pop & head_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= queue_wr.run;
      end
   end

endmodule

`default_nettype wire

// File: design/usan_back.sv
// Back end: walks the head run one byte per cycle into the output register while rsp is not stalled.
`default_nettype none

module usan_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire usan_pkg::run_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_end_of_string,
   output logic                   rsp_last_of_run
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       eos_ff, eos_in;
   logic       last_ff, last_in;
   logic [1:0] pos_ff, pos_in;
   logic       load;
   logic       at_last;

   assign load    = ~valid_ff | ~rsp_stall;
   assign at_last = (pos_ff == head.last_idx);

   // Next output word and run position
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      eos_in   = eos_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in = head.bytes[pos_ff];
            eos_in  = head.eos;
            last_in = at_last;
            pop     = at_last;
            pos_in  = at_last ? 2'd0 : pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   // Output payload, no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

`default_nettype wire

// File: design/usan_checker.sv
// Port-level checker for the UTF-8 sanitizer, bound to the top level.
`default_nettype none

module usan_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_end_of_string,
   input wire logic       rsp_last_of_run
);

   // Terminator word carries a zero byte
   a_eos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_out_byte == 8'h00)
      else $error("terminator word with nonzero byte");

   // Terminator is always the last word of its run
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_last_of_run)
      else $error("terminator word not marked last of run");

   // No result word right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // Queue is empty after reset, so input is not stalled
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_end_of_string) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

endmodule

bind utf8_sanitizer_core usan_checker u_usan_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_end_of_string (rsp_end_of_string),
   .rsp_last_of_run   (rsp_last_of_run)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the UTF-8 sanitizer core: directed and random byte streams.

module tb_top;

   localparam int IdleLimit   = 3000;
   localparam int RandomBytes = 170;

   typedef struct {
      logic [7:0] out_byte;
      logic       eos;
      logic       last;
   } san_word_type;

   typedef enum {
      STALL_NONE,
      STALL_RANDOM,
      STALL_HEAVY,
      STALL_BLOCK
   } stall_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_of_string;
   logic       rsp_last_of_run;

   // Predictor state: pending sequence length, bytes held so far, held bytes
   logic [2:0] open_len;
   logic [1:0] held_cnt;
   logic [7:0] held_buf [3];

   san_word_type expected_words [$];
   san_word_type head_word;
   int           err_count;
   int           idle_cycles;
   int           burst_left;

   utf8_sanitizer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Work out the words one input byte releases and queue them up
   function automatic void sanitize_byte(input logic [7:0] b);
      logic [7:0]   run_bytes [$];
      logic         eos;
      logic         is_cont;
      logic         as_lead;
      san_word_type w;
      eos     = 1'b0;
      as_lead = 1'b1;
      is_cont = (b >= usan_pkg::ByteAsciiHi) && (b <= usan_pkg::ByteContHi);
      if (open_len != usan_pkg::SeqLenNone) begin
         if (is_cont) begin
            as_lead = 1'b0;
            if ({1'b0, held_cnt} + 3'd1 == open_len) begin
               for (int i = 0; i < int'(held_cnt); i++) run_bytes.push_back(held_buf[i]);
               run_bytes.push_back(b);
               open_len = usan_pkg::SeqLenNone;
               held_cnt = 2'd0;
            end else begin
               held_buf[held_cnt] = b;
               held_cnt = held_cnt + 2'd1;
            end
         end else begin
            // early break: drop what is held, byte starts over
            open_len = usan_pkg::SeqLenNone;
            held_cnt = 2'd0;
         end
      end
      if (as_lead) begin
         if (b == usan_pkg::ByteZero) begin
            run_bytes.push_back(usan_pkg::ByteZero);
            eos = 1'b1;
         end else if (b < usan_pkg::ByteAsciiHi) begin
            run_bytes.push_back(b);
         end else if (b >= usan_pkg::ByteLead2Lo && b <= usan_pkg::ByteLead2Hi) begin
            open_len = usan_pkg::SeqLen2;
         end else if (b >= usan_pkg::ByteLead3Lo && b <= usan_pkg::ByteLead3Hi) begin
            open_len = usan_pkg::SeqLen3;
         end else if (b >= usan_pkg::ByteLead4Lo && b <= usan_pkg::ByteLead4Hi) begin
            open_len = usan_pkg::SeqLen4;
         end
         if (open_len != usan_pkg::SeqLenNone) begin
            held_buf[0] = b;
            held_cnt    = 2'd1;
         end
      end
      for (int i = 0; i < run_bytes.size(); i++) begin
         w.out_byte = run_bytes[i];
         w.eos      = eos;
         w.last     = (i == run_bytes.size() - 1);
         expected_words.push_back(w);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
      err_count++;
   endtask

   // Offer one byte, hold it until taken, then predict
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sanitize_byte(b);
   endtask

   // Sender bursts: random length, random gap between bursts
   task automatic paced_send(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      send_byte(b);
   endtask

   task automatic send_list(input logic [7:0] list [$]);
      foreach (list[i]) paced_send(list[i]);
   endtask

   // Stop sending until every expected word is out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic test_ascii_and_terminator();
      send_list('{8'h7F, 8'h01, 8'h00});
   endtask

   task automatic test_full_sequences();
      send_list('{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'hBF, 8'h80});
   endtask

   task automatic test_early_break();
      // lead cut by ASCII, partial cut by another lead, lead cut by terminator
      send_list('{8'hDF, 8'h41, 8'hE0, 8'h80, 8'hF4, 8'h00});
   endtask

   task automatic test_stray_and_invalid();
      send_list('{8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF5, 8'hFF});
      send_byte(8'h0A);
   endtask

   // Mostly well-formed sequences with random content, some noise and broken ones
   task automatic test_random_stream();
      int good;
      int kind;
      int len;
      int n_cont;
      logic [7:0] lead;
      good = 0;
      while (good < RandomBytes) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            paced_send(8'($urandom_range(1, 127)));
            good++;
         end else if (kind < 73 || (kind >= 80 && kind < 90)) begin
            len = (kind < 45) ? 2 : (kind < 60) ? 3 : (kind < 73) ? 4 : $urandom_range(2, 4);
            case (len)
               2:       lead = 8'($urandom_range(usan_pkg::ByteLead2Lo, usan_pkg::ByteLead2Hi));
               3:       lead = 8'($urandom_range(usan_pkg::ByteLead3Lo, usan_pkg::ByteLead3Hi));
               default: lead = 8'($urandom_range(usan_pkg::ByteLead4Lo, usan_pkg::ByteLead4Hi));
            endcase
            // broken sequences stop short of the last continuation
            n_cont = (kind < 73) ? len - 1 : $urandom_range(0, len - 2);
            paced_send(lead);
            repeat (n_cont) paced_send(rand_cont());
            if (kind < 73) good += len;
         end else if (kind < 80) begin
            paced_send(usan_pkg::ByteZero);
            good++;
         end else begin
            paced_send(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   // Receiver stall pattern, independent of the sender
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int             span;
      rsp_stall = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               default:      rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // Compare each taken word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, out_byte", rsp_out_byte, 8'h00);
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_out_byte !== head_word.out_byte)
               report_mismatch("out_byte", rsp_out_byte, head_word.out_byte);
            if (rsp_end_of_string !== head_word.eos)
               report_mismatch("end_of_string", {7'd0, rsp_end_of_string},
                               {7'd0, head_word.eos});
            if (rsp_last_of_run !== head_word.last)
               report_mismatch("last_of_run", {7'd0, rsp_last_of_run},
                               {7'd0, head_word.last});
         end
      end
   end

   // Watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      open_len      = usan_pkg::SeqLenNone;
      held_cnt      = 2'd0;
      err_count     = 0;
      idle_cycles   = 0;
      burst_left    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ascii_and_terminator();
      test_full_sequences();
      wait_drained();
      test_early_break();
      test_stray_and_invalid();
      wait_drained();
      test_random_stream();
      wait_drained();
      repeat (20) @(posedge clock);

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
